/* hdl/lcdt_pkg.sv */
// Shared types and timing constants of the scanline mode timer.
// Used by lcdt_step and lcd_scanline_mode_timer; depends on nothing else.
package lcdt_pkg;

    // Mode lengths in clock cycles.
    localparam int SEARCH_CLOCKS      = 80;
    localparam int TRANSFER_CLOCKS    = 172;
    localparam int HBLANK_CLOCKS      = 204;
    localparam int VBLANK_LINE_CLOCKS = 456;

    localparam int CYCLES_W = 7;
    localparam int ACCUM_W  = 10;
    localparam int LINE_W   = 8;
    localparam int IRQ_EN_W = 4;

    // Largest elapsed count taken per beat; more saturates.
    localparam logic [CYCLES_W-1:0] CYCLES_MAX = 7'd80;

    localparam logic [LINE_W-1:0] LINE_VBLANK_START = 8'd144;
    localparam logic [LINE_W-1:0] LINE_WRAP         = 8'd154;

    // Bits of the interrupt enable register.
    localparam int IRQ_HBLANK = 0;
    localparam int IRQ_VBLANK = 1;
    localparam int IRQ_SEARCH = 2;
    localparam int IRQ_MATCH  = 3;

    // Configuration register indexes.
    localparam logic [1:0] REG_LINE_COMPARE = 2'd0;
    localparam logic [1:0] REG_IRQ_ENABLES  = 2'd1;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } mode_t;

    // Timer state carried from beat to beat.
    typedef struct packed {
        logic [ACCUM_W-1:0] accum;
        mode_t              cur_mode;
        logic [LINE_W-1:0]  line;
        mode_t              rep_mode;
        logic               match;
        mode_t              last_mode;
        logic               prev_match;
    } timer_state_t;

    // One result beat.
    typedef struct packed {
        logic              object_scan;
        logic              line_done;
        logic              status_irq;
        logic              frame_irq;
        logic              coincidence;
        logic [LINE_W-1:0] line;
        mode_t             mode;
    } result_t;

endpackage

/* hdl/lcdt_step.sv */
// Combinational step of the scanline mode timer: one beat's update.
// Depends on lcdt_pkg.
module lcdt_step
    import lcdt_pkg::*;
(
    input  logic [CYCLES_W-1:0] cycles,
    input  logic [LINE_W-1:0]   line_compare,
    input  logic [IRQ_EN_W-1:0] irq_enables,
    input  timer_state_t        state_cur,
    output timer_state_t        state_next,
    output result_t             result
);

    logic [CYCLES_W-1:0] sat;
    logic [ACCUM_W-1:0]  acc;
    logic [LINE_W-1:0]   line_inc;
    logic                changed;
    logic                hit;
    logic                req;
    logic                frame;
    logic                done;
    logic                scan;

    assign sat      = (cycles > CYCLES_MAX) ? CYCLES_MAX : cycles;
    assign acc      = state_cur.accum + {{(ACCUM_W-CYCLES_W){1'b0}}, sat};
    assign line_inc = state_cur.line + 8'd1;

    // Mode sequencing: at most one mode change per beat.
    always_comb begin
        state_next = state_cur;
        state_next.accum = acc;
        changed = 1'b0;
        frame   = 1'b0;
        done    = 1'b0;
        scan    = 1'b0;
        unique case (state_cur.cur_mode)
            MODE_SEARCH: begin
                scan = 1'b1;
                if (acc >= ACCUM_W'(SEARCH_CLOCKS)) begin
                    state_next.accum    = acc - ACCUM_W'(SEARCH_CLOCKS);
                    state_next.cur_mode = MODE_TRANSFER;
                    changed = 1'b1;
                end
            end
            MODE_TRANSFER: begin
                if (acc >= ACCUM_W'(TRANSFER_CLOCKS)) begin
                    state_next.accum    = acc - ACCUM_W'(TRANSFER_CLOCKS);
                    state_next.cur_mode = MODE_HBLANK;
                    changed = 1'b1;
                    done    = 1'b1;
                end
            end
            MODE_HBLANK: begin
                if (acc >= ACCUM_W'(HBLANK_CLOCKS)) begin
                    state_next.accum = acc - ACCUM_W'(HBLANK_CLOCKS);
                    state_next.line  = line_inc;
                    changed = 1'b1;
                    if (line_inc == LINE_VBLANK_START) begin
                        state_next.cur_mode = MODE_VBLANK;
                        frame = 1'b1;
                    end else begin
                        state_next.cur_mode = MODE_SEARCH;
                    end
                end
            end
            MODE_VBLANK: begin
                if (acc >= ACCUM_W'(VBLANK_LINE_CLOCKS)) begin
                    state_next.accum = acc - ACCUM_W'(VBLANK_LINE_CLOCKS);
                    state_next.line  = line_inc;
                    // Only the wrap back to line zero counts as a mode change.
                    if (line_inc == LINE_WRAP) begin
                        state_next.line     = '0;
                        state_next.cur_mode = MODE_SEARCH;
                        changed = 1'b1;
                    end
                end
            end
            default: begin
                state_next = state_cur;
            end
        endcase

        // Status latch and interrupt request on a mode change.
        hit = (state_next.line == line_compare);
        req = 1'b0;
        if (changed) begin
            state_next.rep_mode   = state_next.cur_mode;
            state_next.match      = hit;
            state_next.last_mode  = state_next.cur_mode;
            state_next.prev_match = hit;
            if (state_next.cur_mode != state_cur.last_mode) begin
                if (state_next.cur_mode == MODE_HBLANK && irq_enables[IRQ_HBLANK])
                    req = 1'b1;
                if (state_next.cur_mode == MODE_VBLANK && irq_enables[IRQ_VBLANK])
                    req = 1'b1;
                if (state_next.cur_mode == MODE_SEARCH && irq_enables[IRQ_SEARCH])
                    req = 1'b1;
            end
            if (hit && !state_cur.prev_match && irq_enables[IRQ_MATCH])
                req = 1'b1;
        end
    end

    // Result of this beat.
    always_comb begin
        result.mode        = state_next.rep_mode;
        result.line        = state_next.line;
        result.coincidence = state_next.match;
        result.frame_irq   = frame;
        result.status_irq  = req;
        result.line_done   = done;
        result.object_scan = scan;
    end

endmodule

/* hdl/lcd_scanline_mode_timer.sv */
// Top level of the scanline mode timer: stream ports, input and result registers.
// Depends on lcdt_pkg and lcdt_step.

// Each input beat carries the clock cycles elapsed since the previous beat
// (saturated at 80) and yields exactly one result beat with the reported mode,
// the line counter, the coincidence flag and the frame, status and line-done
// pulses. The block takes one beat per clock while m_tready stays high: a beat
// is held in the input register, then the step logic updates the timer state and
// the result register from it. Register writes through cfg_wr_en take effect on
// the next mode change and are meant for when no beat is in flight.
module lcd_scanline_mode_timer
    import lcdt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] cycles
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] mode, [9:2] line, [10] coincidence,
                                   // [11] frame_irq, [12] status_irq,
                                   // [13] line_done, [14] object_scan
);

    logic [LINE_W-1:0]   line_compare_reg;
    logic [IRQ_EN_W-1:0] irq_enables_reg;
    logic                in_valid_reg;
    logic [CYCLES_W-1:0] in_cycles_reg;
    logic                out_valid_reg;
    result_t             out_data_reg;
    timer_state_t        state_reg;
    timer_state_t        state_next;
    result_t             result_next;
    logic                advance;

    // A held beat moves on whenever the result register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    lcdt_step u_step (
        .cycles       (in_cycles_reg),
        .line_compare (line_compare_reg),
        .irq_enables  (irq_enables_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_compare_reg <= '0;
            irq_enables_reg  <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_LINE_COMPARE)
                line_compare_reg <= cfg_wdata[LINE_W-1:0];
            else if (cfg_addr == REG_IRQ_ENABLES)
                irq_enables_reg <= cfg_wdata[IRQ_EN_W-1:0];
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cycles_reg <= s_tdata[CYCLES_W-1:0];
        end
    end

    // Timer state advances once per beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.accum      <= '0;
            state_reg.cur_mode   <= MODE_SEARCH;
            state_reg.line       <= '0;
            state_reg.rep_mode   <= MODE_VBLANK;
            state_reg.match      <= 1'b1;
            state_reg.last_mode  <= MODE_HBLANK;
            state_reg.prev_match <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule
